[hw/rtl/i2cm_pkg.sv]
package i2cm_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int CMD_DEPTH_DEF  = 2;
  localparam int RES_DEPTH_DEF  = 2;

  localparam int LEN_W  = 16;
  localparam int REM_W  = 17;
  localparam int WAIT_W = 16;
  localparam int FREQ_W = 9;
  localparam int CFG_W  = 16;

  // flag_bits positions
  localparam int FLAG_NO_START = 0;
  localparam int FLAG_NO_STOP  = 1;
  localparam int FLAG_NO_ADDR  = 2;

  // bit phase: 32 data quarters, 4 ack quarters, then the byte boundary
  localparam logic [5:0] PH_DATA_END = 6'd32;
  localparam logic [5:0] PH_BYTE_END = 6'd36;

  // half period = 500 / bus_freq_khz, one quotient bit per cycle
  localparam logic [FREQ_W-1:0] DIV_DIVIDEND = 9'd500;
  localparam int                DIV_STEPS    = FREQ_W;
  localparam logic [FREQ_W-1:0] HALF_RESET   = 9'd5;

  // configuration register indexes
  localparam logic CFG_BUS_FREQ = 1'b0;
  localparam logic CFG_BYTE_GAP = 1'b1;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_BEGIN = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    Q_SETUP  = 2'd0,
    Q_RISE   = 2'd1,
    Q_SAMPLE = 2'd2,
    Q_FALL   = 2'd3
  } quarter_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        addr_byte;
    logic [LEN_W-1:0]  length;
    logic [2:0]        flag_bits;
    logic [7:0]        tx_byte;
    logic              scl_level;
    logic              sda_level;
  } cmd_t;

  typedef struct packed {
    logic                    scl_release;
    logic                    sda_release;
    logic [WAIT_W-1:0]       wait_us;
    logic [7:0]              rx_byte;
    logic                    rx_valid;
    logic                    tx_take;
    logic                    done_res;
    logic signed [REM_W-1:0] residue;
  } res_t;

  typedef struct packed {
    logic              div_busy;
    logic [FREQ_W-1:0] half_period;
    logic [WAIT_W-1:0] byte_gap_us;
  } cfg_t;

endpackage

[hw/rtl/i2c_master_bit_engine_core.sv]
// I2C master bit engine: one quarter-bit step of the bus per input transaction.
// Input channel (in_push / in_full): a begin command (in_command = 1) loads the
// address byte, length and flags and takes the first step; tick commands carry
// the sampled SCL/SDA levels and the next transmit byte. Each input transaction
// yields exactly one result on the output channel (out_empty / out_pop): the
// open-drain release levels, the wait in microseconds before the next tick,
// received data, tx_take, done and residue.
// An accepted input is registered in the command queue and its result in the
// result queue before the result reaches the output ports. Throughput is one
// transaction per cycle unless the divider or a full result queue holds the
// step; the step engine evaluates a whole quarter-bit step combinationally.
// Writing bus_freq_khz starts a restoring divider for the half period;
// steps are held in the command queue while it runs.
// Reset (synchronous, rst_n low) empties both queues, returns the engine to
// idle with both lines released, and restores bus_freq_khz 100 and
// byte_gap_us 0.
// When the receiver stalls (out_pop low), results collect in the result queue;
// once it fills, the engine holds and the command queue raises in_full.
module i2c_master_bit_engine_core #(
  parameter int COUNT_BITS = i2cm_pkg::COUNT_BITS_DEF,
  parameter int CMD_DEPTH  = i2cm_pkg::CMD_DEPTH_DEF,
  parameter int RES_DEPTH  = i2cm_pkg::RES_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_command,
  input  logic [7:0]                        in_addr_byte,
  input  logic [i2cm_pkg::LEN_W-1:0]        in_length,
  input  logic [2:0]                        in_flag_bits,
  input  logic [7:0]                        in_tx_byte,
  input  logic                              in_scl_level,
  input  logic                              in_sda_level,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic                              out_scl_release,
  output logic                              out_sda_release,
  output logic [i2cm_pkg::WAIT_W-1:0]       out_wait_us,
  output logic [7:0]                        out_rx_byte,
  output logic                              out_rx_valid,
  output logic                              out_tx_take,
  output logic                              out_done_res,
  output logic signed [i2cm_pkg::REM_W-1:0] out_residue,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [i2cm_pkg::CFG_W-1:0]        cfg_wdata
);

  i2cm_pkg::cmd_t cmd;
  logic           cmd_empty;
  logic           cmd_pop;
  i2cm_pkg::cfg_t cfg;
  i2cm_pkg::res_t res_in;
  i2cm_pkg::res_t res_out;
  logic           res_push;
  logic           res_full;
  logic [$bits(i2cm_pkg::res_t)-1:0] res_bits;

  i2cm_front #(
    .COUNT_BITS (COUNT_BITS),
    .CMD_DEPTH  (CMD_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_command   (in_command),
    .in_addr_byte (in_addr_byte),
    .in_length    (in_length),
    .in_flag_bits (in_flag_bits),
    .in_tx_byte   (in_tx_byte),
    .in_scl_level (in_scl_level),
    .in_sda_level (in_sda_level),
    .cmd_pop      (cmd_pop),
    .cmd          (cmd),
    .cmd_empty    (cmd_empty)
  );

  i2cm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  i2cm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  i2cm_fifo #(
    .WIDTH ($bits(i2cm_pkg::res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_bits),
    .empty (out_empty)
  );

  assign res_out         = i2cm_pkg::res_t'(res_bits);
  assign out_scl_release = res_out.scl_release;
  assign out_sda_release = res_out.sda_release;
  assign out_wait_us     = res_out.wait_us;
  assign out_rx_byte     = res_out.rx_byte;
  assign out_rx_valid    = res_out.rx_valid;
  assign out_tx_take     = res_out.tx_take;
  assign out_done_res    = res_out.done_res;
  assign out_residue     = res_out.residue;

endmodule

[hw/rtl/i2cm_fifo.sv]
module i2cm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push_ok) - CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[hw/rtl/i2cm_front.sv]
module i2cm_front #(
  parameter int COUNT_BITS = i2cm_pkg::COUNT_BITS_DEF,
  parameter int CMD_DEPTH  = i2cm_pkg::CMD_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic                       in_command,
  input  logic [7:0]                 in_addr_byte,
  input  logic [i2cm_pkg::LEN_W-1:0] in_length,
  input  logic [2:0]                 in_flag_bits,
  input  logic [7:0]                 in_tx_byte,
  input  logic                       in_scl_level,
  input  logic                       in_sda_level,
  input  logic                       cmd_pop,
  output i2cm_pkg::cmd_t             cmd,
  output logic                       cmd_empty
);

  // byte counter width limits the usable length
  localparam logic [i2cm_pkg::LEN_W-1:0] LEN_MASK =
    (COUNT_BITS >= i2cm_pkg::LEN_W) ? {i2cm_pkg::LEN_W{1'b1}}
                                    : i2cm_pkg::LEN_W'((64'd1 << COUNT_BITS) - 64'd1);

  i2cm_pkg::cmd_t              cmd_in;
  logic [$bits(i2cm_pkg::cmd_t)-1:0] cmd_bits;

  always_comb begin
    cmd_in.kind      = in_command ? i2cm_pkg::KIND_BEGIN : i2cm_pkg::KIND_TICK;
    cmd_in.addr_byte = in_addr_byte;
    cmd_in.length    = in_length & LEN_MASK;
    cmd_in.flag_bits = in_flag_bits;
    cmd_in.tx_byte   = in_tx_byte;
    cmd_in.scl_level = in_scl_level;
    cmd_in.sda_level = in_sda_level;
  end

  i2cm_fifo #(
    .WIDTH ($bits(i2cm_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty)
  );

  assign cmd = i2cm_pkg::cmd_t'(cmd_bits);

endmodule

[hw/rtl/i2cm_cfg.sv]
module i2cm_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [i2cm_pkg::CFG_W-1:0] cfg_wdata,
  output i2cm_pkg::cfg_t             cfg_o
);

  localparam int FW = i2cm_pkg::FREQ_W;
  localparam int NW = $clog2(i2cm_pkg::DIV_STEPS + 1);

  logic [FW-1:0]                half_r, half_nxt;
  logic [i2cm_pkg::WAIT_W-1:0]  gap_r, gap_nxt;
  logic [NW-1:0]                cnt_r, cnt_nxt;
  logic [FW-1:0]                divisor_r, divisor_nxt;
  logic [FW-1:0]                rem_r, rem_nxt;
  logic [FW-1:0]                quo_r, quo_nxt;
  logic [FW:0]                  trial;
  logic [FW-1:0]                freq;
  logic                         qbit;

  assign freq = cfg_wdata[FW-1:0];

  always_comb begin
    half_nxt    = half_r;
    gap_nxt     = gap_r;
    cnt_nxt     = cnt_r;
    divisor_nxt = divisor_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    trial       = {rem_r, quo_r[FW-1]};
    qbit        = (trial >= {1'b0, divisor_r});

    if (cnt_r != '0) begin
      rem_nxt = qbit ? FW'(trial - {1'b0, divisor_r}) : trial[FW-1:0];
      quo_nxt = {quo_r[FW-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == NW'(1)) begin
        half_nxt = quo_nxt;
      end
    end

    if (cfg_we) begin
      unique case (cfg_index)
        i2cm_pkg::CFG_BUS_FREQ: begin
          // zero runs as 1 kHz
          divisor_nxt = (freq == '0) ? FW'(1) : freq;
          rem_nxt     = '0;
          quo_nxt     = i2cm_pkg::DIV_DIVIDEND;
          cnt_nxt     = NW'(i2cm_pkg::DIV_STEPS);
        end
        i2cm_pkg::CFG_BYTE_GAP: begin
          gap_nxt = cfg_wdata[i2cm_pkg::WAIT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= i2cm_pkg::HALF_RESET;
      gap_r  <= '0;
      cnt_r  <= '0;
    end else begin
      half_r <= half_nxt;
      gap_r  <= gap_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    divisor_r <= divisor_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
  end

  assign cfg_o.div_busy    = (cnt_r != '0);
  assign cfg_o.half_period = half_r;
  assign cfg_o.byte_gap_us = gap_r;

  a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == i2cm_pkg::CFG_BUS_FREQ |=> cfg_o.div_busy)
    else $error("divider did not start on frequency write");

endmodule

[hw/rtl/i2cm_engine.sv]
module i2cm_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  i2cm_pkg::cmd_t cmd,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  input  i2cm_pkg::cfg_t cfg,
  input  logic           res_full,
  output logic           res_push,
  output i2cm_pkg::res_t res
);

  localparam int RW = i2cm_pkg::REM_W;

  logic                 busy_r, busy_nxt;
  logic                 started_r, started_nxt;
  logic                 send_r, send_nxt;
  logic                 recv_r, recv_nxt;
  logic                 addr_r, addr_nxt;
  logic [5:0]           phase_r, phase_nxt;
  logic [7:0]           shift_r, shift_nxt;
  logic                 line_r, line_nxt;
  logic signed [RW-1:0] rem_r, rem_nxt;
  logic [2:0]           mode_r, mode_nxt;
  logic                 scl_r, scl_nxt;
  logic                 sda_r, sda_nxt;

  logic                        inc;
  logic                        fin;
  logic                        enter;
  logic                        data;
  logic [i2cm_pkg::WAIT_W-1:0] delay;

  // hold the step while the half-period divider is still running
  assign cmd_pop  = !cmd_empty && !res_full && !cfg.div_busy;
  assign res_push = cmd_pop;

  always_comb begin
    if (cmd.kind == i2cm_pkg::KIND_BEGIN) begin
      busy_nxt    = 1'b1;
      started_nxt = 1'b0;
      send_nxt    = 1'b0;
      recv_nxt    = 1'b0;
      addr_nxt    = 1'b0;
      phase_nxt   = '0;
      shift_nxt   = cmd.addr_byte;
      rem_nxt     = RW'(signed'({1'b0, cmd.length}));
      mode_nxt    = cmd.flag_bits;
    end else begin
      busy_nxt    = busy_r;
      started_nxt = started_r;
      send_nxt    = send_r;
      recv_nxt    = recv_r;
      addr_nxt    = addr_r;
      phase_nxt   = phase_r;
      shift_nxt   = shift_r;
      rem_nxt     = rem_r;
      mode_nxt    = mode_r;
    end
    line_nxt = line_r;
    scl_nxt  = scl_r;
    sda_nxt  = sda_r;
    res      = '0;
    inc      = 1'b1;
    fin      = 1'b0;
    enter    = 1'b0;
    data     = (phase_nxt < i2cm_pkg::PH_DATA_END);
    delay    = i2cm_pkg::WAIT_W'(cfg.half_period);

    if (busy_nxt) begin
      if (send_nxt || recv_nxt) begin
        delay = i2cm_pkg::WAIT_W'(cfg.half_period >> 1);
        if (phase_nxt == i2cm_pkg::PH_BYTE_END) begin
          if (addr_nxt) begin
            addr_nxt = 1'b0;
            if (recv_nxt) begin
              send_nxt = 1'b0;
            end
          end else begin
            rem_nxt = rem_nxt - RW'(1);
            if (recv_nxt) begin
              res.rx_byte  = shift_nxt;
              res.rx_valid = 1'b1;
              sda_nxt      = 1'b1;
            end
          end
          if (send_nxt && rem_nxt > 0) begin
            shift_nxt   = cmd.tx_byte;
            res.tx_take = 1'b1;
          end
          if (rem_nxt > 0) begin
            if (cfg.byte_gap_us != '0) begin
              delay = cfg.byte_gap_us;
            end
          end else if (mode_nxt[i2cm_pkg::FLAG_NO_STOP]) begin
            fin = 1'b1;
          end else begin
            send_nxt = 1'b0;
            recv_nxt = 1'b0;
          end
          phase_nxt = fin ? phase_nxt : '0;
          inc       = 1'b0;
        end else begin
          case (i2cm_pkg::quarter_t'(phase_nxt[1:0]))
            i2cm_pkg::Q_SETUP: begin
              if (data) begin
                if (send_nxt) begin
                  sda_nxt   = shift_nxt[7];
                  shift_nxt = {shift_nxt[6:0], 1'b0};
                end
              end else if (!addr_nxt && recv_nxt && rem_nxt > 1) begin
                // ack every received byte but the last
                sda_nxt = 1'b0;
              end else begin
                sda_nxt = 1'b1;
              end
            end
            i2cm_pkg::Q_RISE: scl_nxt = 1'b1;
            i2cm_pkg::Q_SAMPLE: begin
              // slave stretching the clock: repeat this quarter
              if (!cmd.scl_level) begin
                inc = 1'b0;
              end else begin
                line_nxt = cmd.sda_level;
              end
            end
            default: begin
              scl_nxt = 1'b0;
              if (!addr_nxt && data && recv_nxt) begin
                shift_nxt = {shift_nxt[6:0], line_nxt};
              end else if (!data && send_nxt && line_nxt) begin
                // nack: an address nack always issues a stop
                if (addr_nxt) begin
                  mode_nxt[i2cm_pkg::FLAG_NO_STOP] = 1'b0;
                  rem_nxt = -RW'(1);
                end
                if (mode_nxt[i2cm_pkg::FLAG_NO_STOP]) begin
                  fin = 1'b1;
                end else begin
                  send_nxt  = 1'b0;
                  recv_nxt  = 1'b0;
                  phase_nxt = '0;
                  inc       = 1'b0;
                end
              end
            end
          endcase
        end
      end else if (!started_nxt) begin
        if (mode_nxt[i2cm_pkg::FLAG_NO_START]) begin
          enter = 1'b1;
        end else if (phase_nxt[5:2] == '0) begin
          case (i2cm_pkg::quarter_t'(phase_nxt[1:0]))
            i2cm_pkg::Q_SETUP: sda_nxt = 1'b1;
            i2cm_pkg::Q_RISE:  scl_nxt = 1'b1;
            i2cm_pkg::Q_SAMPLE: begin
              if (!cmd.scl_level) begin
                inc = 1'b0;
              end else begin
                sda_nxt = 1'b0;
              end
            end
            default: begin
              scl_nxt = 1'b0;
              enter   = 1'b1;
            end
          endcase
        end
        if (enter) begin
          started_nxt = 1'b1;
          if (mode_nxt[i2cm_pkg::FLAG_NO_ADDR]) begin
            recv_nxt = shift_nxt[0];
            send_nxt = !shift_nxt[0];
            if (send_nxt && rem_nxt > 0) begin
              shift_nxt   = cmd.tx_byte;
              res.tx_take = 1'b1;
            end
          end else begin
            addr_nxt = 1'b1;
            send_nxt = 1'b1;
            recv_nxt = shift_nxt[0];
          end
          phase_nxt = '0;
          inc       = 1'b0;
        end
      end else if (mode_nxt[i2cm_pkg::FLAG_NO_STOP]) begin
        fin = 1'b1;
      end else if (phase_nxt[5:2] == '0) begin
        case (i2cm_pkg::quarter_t'(phase_nxt[1:0]))
          i2cm_pkg::Q_SETUP: sda_nxt = 1'b0;
          i2cm_pkg::Q_RISE:  scl_nxt = 1'b1;
          i2cm_pkg::Q_SAMPLE: begin
            if (!cmd.scl_level) begin
              inc = 1'b0;
            end else begin
              sda_nxt = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
      end

      if (fin) begin
        res.done_res = 1'b1;
        res.residue  = rem_nxt;
        rem_nxt      = '0;
        busy_nxt     = 1'b0;
      end else begin
        if (inc) begin
          phase_nxt = phase_nxt + 6'd1;
        end
        res.wait_us = delay;
      end
    end

    res.scl_release = scl_nxt;
    res.sda_release = sda_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      started_r <= 1'b0;
      send_r    <= 1'b0;
      recv_r    <= 1'b0;
      addr_r    <= 1'b0;
      phase_r   <= '0;
      shift_r   <= '0;
      line_r    <= 1'b0;
      rem_r     <= '0;
      mode_r    <= '0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
    end else if (cmd_pop) begin
      busy_r    <= busy_nxt;
      started_r <= started_nxt;
      send_r    <= send_nxt;
      recv_r    <= recv_nxt;
      addr_r    <= addr_nxt;
      phase_r   <= phase_nxt;
      shift_r   <= shift_nxt;
      line_r    <= line_nxt;
      rem_r     <= rem_nxt;
      mode_r    <= mode_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
    end
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && res.done_res |=> !busy_r)
    else $error("engine still busy after done");

  a_rx_tx_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !(res.rx_valid && res.tx_take))
    else $error("receive and transmit in the same step");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= i2cm_pkg::PH_BYTE_END)
    else $error("phase counter out of range");

  a_idle_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && !busy_r && cmd.kind == i2cm_pkg::KIND_TICK
    |-> res.wait_us == '0 && !res.done_res && !res.tx_take)
    else $error("idle tick produced activity");

endmodule
